// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the run queue checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define RRQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Clocked assertion that also holds across reset.
`define RRQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/core/rrq_pkg.sv =====
// Types, constants and codes of the round-robin run queue.
package rrq_pkg;

   localparam int NUM_TASKS_DEF = 64;
   localparam int TASK_W        = 6;
   localparam int SLICE_W       = 8;
   localparam int COUNT_W       = 7;
   localparam logic [SLICE_W-1:0] MAX_SLICE_RESET = 8'd5;

   typedef enum logic [1:0] {
      OP_ENQ  = 2'd0,
      OP_DEQ  = 2'd1,
      OP_PICK = 2'd2,
      OP_TICK = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_QUEUED = 2'd1,
      ST_ABSENT = 2'd2
   } status_type;

   typedef enum logic {
      SLICE_GRANT = 1'b0,
      SLICE_DEC   = 1'b1
   } slice_op_type;

   typedef enum logic [1:0] {
      FSM_CLEAR = 2'd0,
      FSM_IDLE  = 2'd1,
      FSM_EXEC  = 2'd2
   } fsm_type;

   typedef struct packed {
      op_type            mode;
      logic [TASK_W-1:0] task_id;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic               found;
      logic [TASK_W-1:0]  chosen_task;
      logic [SLICE_W-1:0] slice_left;
      logic               resched;
      logic [COUNT_W-1:0] queued_count;
   } rsp_type;

endpackage

// ===== rtl/core/round_robin_run_queue_core.sv =====
// Round-robin run queue of task numbers with per-task time slices.
// After reset the block sweeps its membership/slice memory, entry by entry,
// and accepts no transaction until the sweep ends (max_slice writes are
// taken throughout). Afterwards each transaction first reads the task's
// membership/slice entry and its two list links from registered-read
// memories, then updates the list and slice through the shared slice unit
// and loads the result register. The result register lets the next
// transaction be accepted while a result still waits; execution stalls
// only while that register is full and not taken.
module round_robin_run_queue_core
   import rrq_pkg::*;
#(
   parameter int NUM_TASKS = NUM_TASKS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [SLICE_W-1:0] csr_data
);

   localparam int IW   = $clog2(NUM_TASKS);
   localparam int ST_W = SLICE_W + 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TASKS - 1);

   // Control and payload registers
   fsm_type            state_ff, state_in;
   logic [IW-1:0]      clr_addr_ff, clr_addr_in;
   op_type             op_ff, op_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic               in_range_ff, in_range_in;
   logic [IW-1:0]      head_ff, head_in;
   logic [IW-1:0]      tail_ff, tail_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SLICE_W-1:0] max_slice_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff, rsp_next;
   logic               rsp_load;

   // Memory ports
   logic            st_we, st_re;
   logic [IW-1:0]   st_waddr, st_raddr;
   logic [ST_W-1:0] st_wdata, st_rdata;
   logic            nx_we, pv_we, link_re;
   logic [IW-1:0]   nx_waddr, nx_wdata, pv_waddr, pv_wdata;
   logic [IW-1:0]   nx_rdata, pv_rdata;

   // Request decode
   logic [11:0]        req_wide;
   logic [IW-1:0]      req_idx;
   logic               req_in_range;
   logic [11:0]        head_wide;
   logic               rd_iq;
   logic [SLICE_W-1:0] rd_slice;
   slice_op_type       su_op;
   logic [SLICE_W-1:0] su_slice;

   assign req_wide     = {6'b0, req_data.task_id};
   assign req_idx      = req_wide[IW-1:0];
   assign req_in_range = ({7'b0, req_data.task_id} < 13'(NUM_TASKS));
   assign head_wide    = 12'(head_ff);
   assign rd_iq        = st_rdata[SLICE_W];
   assign rd_slice     = st_rdata[SLICE_W-1:0];
   assign su_op        = (op_ff == OP_TICK) ? SLICE_DEC : SLICE_GRANT;

   rrq_ram #(.WIDTH(ST_W), .DEPTH(NUM_TASKS)) u_status_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_en   (st_re),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   rrq_ram #(.WIDTH(IW), .DEPTH(NUM_TASKS)) u_next_ram (
      .clock   (clock),
      .wr_en   (nx_we),
      .wr_addr (nx_waddr),
      .wr_data (nx_wdata),
      .rd_en   (link_re),
      .rd_addr (idx_in),
      .rd_data (nx_rdata)
   );

   rrq_ram #(.WIDTH(IW), .DEPTH(NUM_TASKS)) u_prev_ram (
      .clock   (clock),
      .wr_en   (pv_we),
      .wr_addr (pv_waddr),
      .wr_data (pv_wdata),
      .rd_en   (link_re),
      .rd_addr (idx_in),
      .rd_data (pv_rdata)
   );

   rrq_slice_unit u_slice_unit (
      .op        (su_op),
      .slice_cur (rd_slice),
      .max_slice (max_slice_ff),
      .slice_new (su_slice)
   );

   // Sequencer: next state, memory control and result
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      op_in       = op_ff;
      idx_in      = req_idx;
      in_range_in = in_range_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      req_ready   = 1'b0;
      st_we       = 1'b0;
      st_waddr    = idx_ff;
      st_wdata    = '0;
      st_re       = 1'b0;
      st_raddr    = (req_data.mode == OP_PICK) ? head_ff : req_idx;
      nx_we       = 1'b0;
      nx_waddr    = tail_ff;
      nx_wdata    = idx_ff;
      pv_we       = 1'b0;
      pv_waddr    = idx_ff;
      pv_wdata    = tail_ff;
      link_re     = 1'b0;
      rsp_load    = 1'b0;
      rsp_next    = '{status: ST_OK, found: 1'b0, chosen_task: '0, slice_left: '0,
                      resched: 1'b0, queued_count: count_ff};
      unique case (state_ff)
         // Clear membership and slices, one entry a cycle
         FSM_CLEAR: begin
            st_we       = 1'b1;
            st_waddr    = clr_addr_ff;
            clr_addr_in = clr_addr_ff + IW'(1);
            if (clr_addr_ff == LAST_IDX) begin
               state_in = FSM_IDLE;
            end
         end
         // Take a transaction and start its memory reads
         FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               st_re       = 1'b1;
               link_re     = 1'b1;
               op_in       = req_data.mode;
               in_range_in = req_in_range;
               state_in    = FSM_EXEC;
            end
         end
         // Update the list and slice, load the result
         FSM_EXEC: begin
            idx_in = idx_ff;
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = FSM_IDLE;
               if (op_ff == OP_PICK) begin
                  if (count_ff != '0) begin
                     rsp_next.found       = 1'b1;
                     rsp_next.chosen_task = head_wide[TASK_W-1:0];
                     rsp_next.slice_left  = rd_slice;
                  end
               end else if (in_range_ff) begin
                  rsp_next.slice_left = rd_slice;
                  unique case (op_ff)
                     OP_ENQ: begin
                        if (rd_iq) begin
                           rsp_next.status = ST_QUEUED;
                        end else begin
                           // Append at the tail
                           if (count_ff == '0) begin
                              head_in = idx_ff;
                           end else begin
                              nx_we = 1'b1;
                              pv_we = 1'b1;
                           end
                           tail_in  = idx_ff;
                           st_we    = 1'b1;
                           st_wdata = {1'b1, su_slice};
                           count_in = count_ff + COUNT_W'(1);
                           rsp_next.slice_left   = su_slice;
                           rsp_next.queued_count = count_ff + COUNT_W'(1);
                        end
                     end
                     OP_DEQ: begin
                        if (!rd_iq) begin
                           rsp_next.status = ST_ABSENT;
                        end else begin
                           // Unlink from any position
                           if (idx_ff == head_ff) begin
                              head_in = nx_rdata;
                           end else begin
                              nx_we    = 1'b1;
                              nx_waddr = pv_rdata;
                              nx_wdata = nx_rdata;
                           end
                           if (idx_ff == tail_ff) begin
                              tail_in = pv_rdata;
                           end else begin
                              pv_we    = 1'b1;
                              pv_waddr = nx_rdata;
                              pv_wdata = pv_rdata;
                           end
                           st_we    = 1'b1;
                           st_wdata = {1'b0, rd_slice};
                           if (count_ff != '0) begin
                              count_in              = count_ff - COUNT_W'(1);
                              rsp_next.queued_count = count_ff - COUNT_W'(1);
                           end
                        end
                     end
                     OP_TICK: begin
                        st_we               = 1'b1;
                        st_wdata            = {rd_iq, su_slice};
                        rsp_next.slice_left = su_slice;
                        rsp_next.resched    = (su_slice == '0);
                     end
                     OP_PICK: begin
                        rsp_next.slice_left = rd_slice;
                     end
                  endcase
               end
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // State and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_CLEAR;
         clr_addr_ff  <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         max_slice_ff <= MAX_SLICE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         if (csr_valid) begin
            max_slice_ff <= csr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Transaction payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      in_range_ff <= in_range_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/rrq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rrq_slice_unit.sv =====
// Shared slice arithmetic: grant on enqueue, countdown on tick.
module rrq_slice_unit
   import rrq_pkg::*;
(
   input  slice_op_type       op,
   input  logic [SLICE_W-1:0] slice_cur,
   input  logic [SLICE_W-1:0] max_slice,
   output logic [SLICE_W-1:0] slice_new
);

   logic is_zero;

   assign is_zero = (slice_cur == '0);

   always_comb begin
      unique case (op)
         // Clamp a zero or oversized slice to the maximum
         SLICE_GRANT: begin
            slice_new = (is_zero || (slice_cur > max_slice)) ? max_slice : slice_cur;
         end
         // Count down, saturating at zero
         SLICE_DEC: begin
            slice_new = is_zero ? slice_cur : slice_cur - SLICE_W'(1);
         end
      endcase
   end

endmodule

// ===== rtl/core/rrq_checker.sv =====
// Port-level checker for the run queue, bound to the top level.
`include "assert_macros.svh"

module rrq_checker
   import rrq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // Hold a stalled result transaction
   `RRQ_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result changed while stalled")

   // Only a successful pick reports a found task
   `RRQ_ASSERT(a_found_ok, rsp_valid && rsp_data.found |-> rsp_data.status == ST_OK && !rsp_data.resched, "found with error or resched")

   // Without a found task the chosen task reads zero
   `RRQ_ASSERT(a_chosen_zero, rsp_valid && !rsp_data.found |-> rsp_data.chosen_task == '0, "chosen task without found")

   // A reschedule comes only from a successful tick with an empty slice
   `RRQ_ASSERT(a_resched, rsp_valid && rsp_data.resched |-> rsp_data.status == ST_OK && rsp_data.slice_left == '0, "resched with slice left")

   // Drop the result channel and input channel on reset
   `RRQ_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid && !(req_valid && req_ready), "activity right after reset")

endmodule

bind round_robin_run_queue_core rrq_checker u_rrq_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the round-robin run queue core.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import rrq_pkg::*;

   localparam int ID_MAX = NUM_TASKS_DEF - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [SLICE_W-1:0] csr_data = MAX_SLICE_RESET;

   // Shadow copy of the run queue state
   bit [TASK_W-1:0] next_of [NUM_TASKS_DEF];
   bit [TASK_W-1:0] prev_of [NUM_TASKS_DEF];
   bit queued_flag [NUM_TASKS_DEF];
   bit [SLICE_W-1:0] slice_of [NUM_TASKS_DEF];
   bit [TASK_W-1:0] head_id;
   bit [TASK_W-1:0] tail_id;
   bit [COUNT_W-1:0] run_count;
   bit [SLICE_W-1:0] max_slice_cfg = MAX_SLICE_RESET;

   rsp_type pending_results[$];
   int mismatch_count = 0;

   bit sender_idles = 1'b1;
   bit receiver_idles = 1'b1;
   bit hold_off = 1'b0;
   bit rsp_fire = 1'b0;
   int rsp_wait = 0;

   round_robin_run_queue_core #(.NUM_TASKS(NUM_TASKS_DEF)) u_top (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_data,
      .rsp_valid,
      .rsp_ready,
      .rsp_data,
      .csr_valid,
      .csr_ready,
      .csr_data
   );

   always #5 clock = ~clock;

   // Apply one operation to the shadow queue and return its result
   function automatic rsp_type run_queue_step(input req_type item);
      rsp_type res;
      bit [TASK_W-1:0] t;
      bit [TASK_W-1:0] nx;
      bit [TASK_W-1:0] pv;
      res = '0;
      t = item.task_id;
      case (item.mode)
         OP_PICK: begin
            if (run_count != 0) begin
               res.found = 1'b1;
               res.chosen_task = head_id;
               res.slice_left = slice_of[head_id];
            end
         end
         OP_ENQ: begin
            if (queued_flag[t]) begin
               res.status = ST_QUEUED;
            end else begin
               if (run_count == 0) begin
                  head_id = t;
               end else begin
                  next_of[tail_id] = t;
                  prev_of[t] = tail_id;
               end
               tail_id = t;
               queued_flag[t] = 1'b1;
               if (slice_of[t] == 0 || slice_of[t] > max_slice_cfg) slice_of[t] = max_slice_cfg;
               run_count = run_count + COUNT_W'(1);
            end
            res.slice_left = slice_of[t];
         end
         OP_DEQ: begin
            if (!queued_flag[t]) begin
               res.status = ST_ABSENT;
            end else begin
               nx = next_of[t];
               pv = prev_of[t];
               if (t == head_id) head_id = nx;
               else next_of[pv] = nx;
               if (t == tail_id) tail_id = pv;
               else prev_of[nx] = pv;
               queued_flag[t] = 1'b0;
               if (run_count != 0) run_count = run_count - COUNT_W'(1);
            end
            res.slice_left = slice_of[t];
         end
         default: begin
            // tick: count down a nonzero slice, flag reschedule once spent
            if (slice_of[t] != 0) slice_of[t] = slice_of[t] - SLICE_W'(1);
            res.resched = (slice_of[t] == 0);
            res.slice_left = slice_of[t];
         end
      endcase
      res.queued_count = run_count;
      return res;
   endfunction

   function automatic string fmt_result(input rsp_type r);
      return $sformatf("status=%0d found=%0d task=%0d slice=%0d resched=%0d count=%0d",
                       r.status, r.found, r.chosen_task, r.slice_left, r.resched,
                       r.queued_count);
   endfunction

   // Compare one accepted result with the oldest expectation
   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (pending_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected result: %s", fmt_result(got));
         return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.found !== want.found ||
          got.chosen_task !== want.chosen_task || got.slice_left !== want.slice_left ||
          got.resched !== want.resched || got.queued_count !== want.queued_count) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch: expected %s, actual %s", fmt_result(want), fmt_result(got));
      end
   endtask

   // Sample the result handshake while signals are stable
   always @(negedge clock) begin
      rsp_fire = !reset && rsp_valid && rsp_ready;
      if (rsp_fire) check_result(rsp_data);
   end

   // Drive rsp_ready: random stalls after transactions while receiver_idles is set, long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait <= 0;
      end else if (hold_off) begin
         rsp_ready <= 1'b0;
      end else if (rsp_ready) begin
         if (rsp_fire && receiver_idles) begin
            rsp_wait <= $urandom_range(0, 6);
            if (rsp_wait != 0 || $urandom_range(0, 1) == 1) rsp_ready <= 1'b0;
         end
      end else if (rsp_wait != 0) begin
         rsp_wait <= rsp_wait - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Offer one transaction, hold it until accepted, then record its result
   task automatic send_op(input op_type m, input logic [TASK_W-1:0] id);
      int gap;
      bit took;
      req_type item;
      item.mode = m;
      item.task_id = id;
      gap = sender_idles ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end while (!took);
      pending_results.push_back(run_queue_step(item));
   endtask

   // Write max_slice once the block has drained
   task automatic write_max_slice(input logic [SLICE_W-1:0] value);
      bit took;
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do begin
         @(negedge clock);
         took = csr_ready;
         @(posedge clock);
      end while (!took);
      csr_valid <= 1'b0;
      max_slice_cfg = value;
   endtask

   function automatic logic [TASK_W-1:0] any_member();
      int start;
      int k;
      start = $urandom_range(0, ID_MAX);
      for (k = 0; k < NUM_TASKS_DEF; k++)
         if (queued_flag[(start + k) % NUM_TASKS_DEF])
            return TASK_W'((start + k) % NUM_TASKS_DEF);
      return '0;
   endfunction

   function automatic op_type draw_op(input int w_enq, input int w_deq, input int w_pick,
                                      input int w_tick);
      int roll;
      roll = $urandom_range(0, w_enq + w_deq + w_pick + w_tick - 1);
      if (roll < w_enq) return OP_ENQ;
      if (roll < w_enq + w_deq) return OP_DEQ;
      if (roll < w_enq + w_deq + w_pick) return OP_PICK;
      return OP_TICK;
   endfunction

   // Weighted random operations; dequeue and tick mostly target live tasks
   task automatic run_random_ops(input int n, input int w_enq, input int w_deq,
                                 input int w_pick, input int w_tick);
      op_type m;
      logic [TASK_W-1:0] id;
      repeat (n) begin
         m = draw_op(w_enq, w_deq, w_pick, w_tick);
         id = TASK_W'($urandom_range(0, ID_MAX));
         if (m == OP_DEQ && run_count != 0 && $urandom_range(0, 9) < 8)
            id = any_member();
         else if (m == OP_TICK && run_count != 0 && $urandom_range(0, 9) < 6)
            id = head_id;
         send_op(m, id);
      end
   endtask

   task automatic test_directed();
      // empty queue: pick, dequeue of an absent task, tick of a zero slice
      send_op(OP_PICK, 6'd63);
      send_op(OP_DEQ, 6'd63);
      send_op(OP_TICK, 6'd0);
      // build a short list, including an enqueue of a task already queued
      send_op(OP_ENQ, 6'd0);
      send_op(OP_ENQ, 6'd63);
      send_op(OP_ENQ, 6'd0);
      send_op(OP_ENQ, 6'd42);
      send_op(OP_PICK, 6'd0);
      send_op(OP_DEQ, 6'd63);
      // run the head's slice out, then tick once more past zero
      repeat (6) send_op(OP_TICK, 6'd0);
      send_op(OP_DEQ, 6'd0);
      send_op(OP_PICK, 6'd21);
      send_op(OP_DEQ, 6'd42);
      send_op(OP_PICK, 6'd21);
      // largest slice
      write_max_slice(8'd255);
      send_op(OP_ENQ, 6'd21);
      send_op(OP_ENQ, 6'd0);
      // zero max_slice: a fresh task keeps a zero slice
      write_max_slice(8'd0);
      send_op(OP_ENQ, 6'd7);
      send_op(OP_TICK, 6'd7);
      // oversized slice is clipped on enqueue
      write_max_slice(8'd1);
      send_op(OP_DEQ, 6'd21);
      send_op(OP_ENQ, 6'd21);
      write_max_slice(MAX_SLICE_RESET);
   endtask

   task automatic test_fill_and_drain();
      sender_idles = 1'b1;
      receiver_idles <= 1'b0;
      run_random_ops(150, 70, 10, 10, 10);
      sender_idles = 1'b0;
      receiver_idles <= 1'b1;
      run_random_ops(150, 10, 60, 10, 20);
   endtask

   task automatic test_slice_settings();
      sender_idles = 1'b1;
      receiver_idles <= 1'b1;
      write_max_slice(8'd1);
      run_random_ops(60, 30, 25, 15, 30);
      write_max_slice(8'd0);
      run_random_ops(60, 30, 25, 15, 30);
      write_max_slice(8'($urandom_range(2, 254)));
      run_random_ops(60, 30, 25, 15, 30);
      write_max_slice(8'd255);
      run_random_ops(40, 30, 25, 15, 30);
   endtask

   // Hold the result side off long enough for the input to stall
   task automatic test_backpressure();
      sender_idles = 1'b0;
      fork
         begin
            hold_off <= 1'b1;
            repeat (120) @(posedge clock);
            hold_off <= 1'b0;
         end
         run_random_ops(40, 40, 20, 20, 20);
      join
   endtask

   task automatic test_steady_stream();
      sender_idles = 1'b0;
      receiver_idles <= 1'b0;
      run_random_ops(60, 30, 25, 20, 25);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill_and_drain();
      test_slice_settings();
      test_backpressure();
      test_steady_stream();
      // drain outstanding results, then allow for stray ones
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("** round_robin_run_queue_core: PASSED **");
      else
         $display("** round_robin_run_queue_core: FAILED **");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("** round_robin_run_queue_core: FAILED **");
      $finish;
   end

endmodule
